@@ design/led_blink_code_sequencer_macros.svh @@
// Assertion macros shared by the blink-code sequencer RTL.
// Uses the clock i_clk and the active-low reset i_rst_n of the including module.
`ifndef LED_BLINK_CODE_SEQUENCER_MACROS_SVH
`define LED_BLINK_CODE_SEQUENCER_MACROS_SVH
`ifndef SYNTH
// Consequent checked in the same cycle as the antecedent.
`define LBCS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lbcs assertion failed: label");
// Consequent checked in the cycle after the antecedent.
`define LBCS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lbcs assertion failed: label");
`else
`define LBCS_ASSERT_SAME(label, ante, cons)
`define LBCS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ design/led_bcs_pkg.sv @@
// Package for the blink-code sequencer: opcodes, phases, register indexes and structs.
// No dependencies; imported by led_bcs_core, led_blink_code_sequencer and the testbench.
`default_nettype none

package led_bcs_pkg;

    localparam int unsigned LEVEL_W = 8;
    localparam int unsigned TICKS_W = 8;

    typedef enum logic [1:0] {
        OP_TICK      = 2'd0,
        OP_START     = 2'd1,
        OP_SET_COLOR = 2'd2
    } t_opcode;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_PRE_ON   = 3'd1,
        PH_ON       = 3'd2,
        PH_OFF      = 3'd3,
        PH_POST_OFF = 3'd4
    } t_phase;

    // Configuration register indexes
    localparam logic [1:0] CFG_PRE_ON   = 2'd0;
    localparam logic [1:0] CFG_ON       = 2'd1;
    localparam logic [1:0] CFG_OFF      = 2'd2;
    localparam logic [1:0] CFG_POST_OFF = 2'd3;

    localparam logic [TICKS_W-1:0] PRE_ON_RESET   = 8'd5;
    localparam logic [TICKS_W-1:0] ON_RESET       = 8'd2;
    localparam logic [TICKS_W-1:0] OFF_RESET      = 8'd2;
    localparam logic [TICKS_W-1:0] POST_OFF_RESET = 8'd5;

    typedef struct packed {
        logic [TICKS_W-1:0] pre_on_ticks;
        logic [TICKS_W-1:0] on_ticks;
        logic [TICKS_W-1:0] off_ticks;
        logic [TICKS_W-1:0] post_off_ticks;
    } t_cfg;

    typedef struct packed {
        logic               pixel_write;
        logic [LEVEL_W-1:0] pixel_red;
        logic [LEVEL_W-1:0] pixel_green;
        logic [LEVEL_W-1:0] pixel_blue;
        logic               busy_res;
    } t_result;

endpackage

`default_nettype wire

@@ design/led_bcs_core.sv @@
// Sequencer state and per-item next-state logic of the blink-code sequencer.
// Depends on led_bcs_pkg.
`default_nettype none

module led_bcs_core
    import led_bcs_pkg::*;
(
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_fire,
    input  wire  [1:0]          i_opcode,
    input  wire  [LEVEL_W-1:0]  i_red,
    input  wire  [LEVEL_W-1:0]  i_green,
    input  wire  [LEVEL_W-1:0]  i_blue,
    input  wire  [TICKS_W-1:0]  i_blink_times,
    input  wire  t_cfg          i_cfg,
    output t_result             o_res
);

    t_phase             r_phase,   n_phase;
    logic [TICKS_W-1:0] r_count,   n_count;
    logic [TICKS_W-1:0] r_flashes, n_flashes;
    logic [LEVEL_W-1:0] r_red,     n_red;
    logic [LEVEL_W-1:0] r_green,   n_green;
    logic [LEVEL_W-1:0] r_blue,    n_blue;

    logic [TICKS_W-1:0] count_dec;
    logic [TICKS_W-1:0] flashes_dec;
    logic               color_lit;

    assign count_dec   = r_count - 1'b1;
    assign flashes_dec = (r_flashes != '0) ? r_flashes - 1'b1 : '0;
    assign color_lit   = (r_red != '0) || (r_green != '0) || (r_blue != '0);

    always_comb begin
        n_phase   = r_phase;
        n_count   = r_count;
        n_flashes = r_flashes;
        n_red     = r_red;
        n_green   = r_green;
        n_blue    = r_blue;
        o_res     = '0;

        unique case (i_opcode)
            OP_TICK: begin
                priority if (r_phase == PH_IDLE) begin
                    if (color_lit) begin
                        o_res.pixel_write = 1'b1;
                        o_res.pixel_red   = r_red;
                        o_res.pixel_green = r_green;
                        o_res.pixel_blue  = r_blue;
                    end
                end else if (r_phase == PH_PRE_ON && r_flashes == '0 && r_count == '0) begin
                    // A zero flash count goes straight to the trailing gap.
                    o_res.pixel_write = 1'b1;
                    n_count           = i_cfg.post_off_ticks;
                    n_phase           = PH_POST_OFF;
                end else if (r_count == '0) begin
                    // First tick of a phase loads its length and draws the pixel.
                    o_res.pixel_write = 1'b1;
                    unique case (r_phase)
                        PH_ON: begin
                            n_count           = i_cfg.on_ticks;
                            o_res.pixel_red   = r_red;
                            o_res.pixel_green = r_green;
                            o_res.pixel_blue  = r_blue;
                        end
                        PH_PRE_ON: n_count = i_cfg.pre_on_ticks;
                        PH_OFF:    n_count = i_cfg.off_ticks;
                        default:   n_count = i_cfg.post_off_ticks;
                    endcase
                end else begin
                    n_count = count_dec;
                    if (count_dec == '0) begin
                        unique case (r_phase)
                            PH_PRE_ON: n_phase = PH_ON;
                            PH_ON:     n_phase = PH_OFF;
                            PH_OFF: begin
                                n_flashes = flashes_dec;
                                n_phase   = (flashes_dec != '0) ? PH_ON : PH_POST_OFF;
                            end
                            default:   n_phase = PH_IDLE;
                        endcase
                    end
                end
            end
            OP_START: begin
                // The countdown is left alone, so a running count finishes first.
                n_flashes = i_blink_times;
                n_phase   = PH_PRE_ON;
            end
            OP_SET_COLOR: begin
                n_red   = i_red;
                n_green = i_green;
                n_blue  = i_blue;
            end
            default: begin
            end
        endcase

        o_res.busy_res = (n_phase != PH_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_count   <= '0;
            r_flashes <= '0;
            r_red     <= '0;
            r_green   <= '0;
            r_blue    <= '0;
        end else if (i_fire) begin
            r_phase   <= n_phase;
            r_count   <= n_count;
            r_flashes <= n_flashes;
            r_red     <= n_red;
            r_green   <= n_green;
            r_blue    <= n_blue;
        end
    end

endmodule

`default_nettype wire

@@ design/led_blink_code_sequencer.sv @@
// Top level of the blink-code sequencer: stream ports, configuration registers, result register.
// Depends on led_bcs_pkg, led_bcs_core and led_blink_code_sequencer_macros.svh.
`default_nettype none
`include "led_blink_code_sequencer_macros.svh"

// Blink-code sequencer for one RGB pixel. Each input transfer carries an opcode
// in tuser: a tick advances the sequence, a start loads a flash count and
// (re)enters the dark gap before the first flash, and a set-colour stores the
// steady colour. Every input transfer produces exactly one output transfer,
// which reports whether the pixel is to be written, the level to write and
// whether a sequence is still running. Each phase spends one tick loading its
// length from the configuration registers (the pixel is drawn on that tick)
// and then counts down one per tick; when idle, a tick redraws the steady
// colour if it is not black. One item is taken every clock cycle while the output
// is not stalled: the state update is a single pass of logic from the input port
// into the state and the result register, and the input side stays ready while
// the result register is empty or being drained in the same cycle. Each result is
// registered and valid in the cycle after its item. Configuration writes are always
// taken and should only be made while no results are outstanding.
module led_blink_code_sequencer
    import led_bcs_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,

    // Input stream
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [31:0] s_axis_tdata,   // [7:0] red_in, [15:8] green_in, [23:16] blue_in,
                                        // [31:24] blink_times
    input  wire  [1:0]  s_axis_tuser,   // [1:0] opcode

    // Output stream
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [7:0] pixel_red, [15:8] pixel_green,
                                        // [23:16] pixel_blue, [24] busy_res, [31:25] zero
    output logic [0:0]  m_axis_tuser,   // [0] pixel_write

    // Configuration write channel
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [1:0]  i_cfg_index,
    input  wire  [7:0]  i_cfg_data
);

    t_cfg    r_cfg;
    t_result core_res;
    t_result r_out;
    logic    r_out_valid;
    logic    in_fire;
    logic    out_fire;

    // Configuration registers: always ready, one register per transfer.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pre_on_ticks   <= PRE_ON_RESET;
            r_cfg.on_ticks       <= ON_RESET;
            r_cfg.off_ticks      <= OFF_RESET;
            r_cfg.post_off_ticks <= POST_OFF_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_PRE_ON:   r_cfg.pre_on_ticks   <= i_cfg_data;
                CFG_ON:       r_cfg.on_ticks       <= i_cfg_data;
                CFG_OFF:      r_cfg.off_ticks      <= i_cfg_data;
                CFG_POST_OFF: r_cfg.post_off_ticks <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // The input side is open whenever the result register can take a new result.
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_fire      = r_out_valid && m_axis_tready;

    led_bcs_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (in_fire),
        .i_opcode      (s_axis_tuser),
        .i_red         (s_axis_tdata[7:0]),
        .i_green       (s_axis_tdata[15:8]),
        .i_blue        (s_axis_tdata[23:16]),
        .i_blink_times (s_axis_tdata[31:24]),
        .i_cfg         (r_cfg),
        .o_res         (core_res)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire) begin
            r_out_valid <= 1'b1;
        end else if (out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_out <= core_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.pixel_write;
    assign m_axis_tdata  = {7'd0, r_out.busy_res, r_out.pixel_blue,
                            r_out.pixel_green, r_out.pixel_red};

    // A held result blocks the input side until it is taken.
    `LBCS_ASSERT_SAME(a_hold_blocks_input, r_out_valid && !m_axis_tready, !s_axis_tready)
    // Every accepted item leaves a result in the register on the next cycle.
    `LBCS_ASSERT_NEXT(a_result_follows, in_fire, r_out_valid)
    // A start always leaves a sequence running.
    `LBCS_ASSERT_NEXT(a_start_busy, in_fire && s_axis_tuser == OP_START, r_out.busy_res)
    // Outside a sequence the pixel is only ever written with a lit colour.
    `LBCS_ASSERT_SAME(a_idle_write_lit,
        r_out_valid && r_out.pixel_write && !r_out.busy_res,
        r_out.pixel_red != '0 || r_out.pixel_green != '0 || r_out.pixel_blue != '0)

endmodule

`default_nettype wire

@@ verif/tb_led_blink_code_sequencer.sv @@
// Self-checking testbench for the blink-code sequencer: a directed opening, then random
// blink sequences over several timing settings, with an in-bench predictor of every result.
// Depends on led_bcs_pkg and the led_blink_code_sequencer RTL.
`default_nettype none

module tb_led_blink_code_sequencer;
    import led_bcs_pkg::*;

    // Opcode value that the block must ignore (it still returns one result).
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // One input transfer: opcode for tuser, packed fields for tdata.
    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] data;   // [7:0] red, [15:8] green, [23:16] blue, [31:24] blink count
    } t_stim;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = OP_TICK;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = CFG_PRE_ON;
    logic [7:0]  i_cfg_data = '0;

    led_blink_code_sequencer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Items waiting to be offered, and pixel results owed by the block, oldest first.
    t_stim   items_to_send[$];
    t_result pixel_due[$];
    t_stim   on_offer;
    int      items_queued = 0;
    int      mismatches = 0;

    // Stall controls: calm switches random idling off on both sides, hold_off keeps the
    // output side blocked so that the block backs up into its input.
    logic    calm = 1'b0;
    logic    hold_off = 1'b0;

    // Predictor state, starting from the reset values of the block.
    logic [7:0] tim_pre_on = PRE_ON_RESET;
    logic [7:0] tim_on = ON_RESET;
    logic [7:0] tim_off = OFF_RESET;
    logic [7:0] tim_post_off = POST_OFF_RESET;
    t_phase     seq_phase = PH_IDLE;
    logic [7:0] seq_count = '0;
    logic [7:0] flashes_owed = '0;
    logic [7:0] steady_red = '0;
    logic [7:0] steady_green = '0;
    logic [7:0] steady_blue = '0;

    // Works out the result of one accepted item and advances the predicted sequence.
    function automatic t_result predict_pixel(input t_stim it);
        t_result r;
        r = '0;
        case (it.op)
            OP_TICK: begin
                if (seq_phase == PH_IDLE) begin
                    // Idle ticks redraw the steady colour unless it is black.
                    if ({steady_red, steady_green, steady_blue} != '0) begin
                        r.pixel_write = 1'b1;
                        r.pixel_red   = steady_red;
                        r.pixel_green = steady_green;
                        r.pixel_blue  = steady_blue;
                    end
                end else if (seq_phase == PH_PRE_ON && flashes_owed == 0 && seq_count == 0) begin
                    // A zero flash count goes straight to the closing dark gap.
                    r.pixel_write = 1'b1;
                    seq_count     = tim_post_off;
                    seq_phase     = PH_POST_OFF;
                end else if (seq_count == 0) begin
                    // First tick of a phase: load its length and draw the pixel.
                    r.pixel_write = 1'b1;
                    case (seq_phase)
                        PH_ON: begin
                            seq_count     = tim_on;
                            r.pixel_red   = steady_red;
                            r.pixel_green = steady_green;
                            r.pixel_blue  = steady_blue;
                        end
                        PH_PRE_ON: seq_count = tim_pre_on;
                        PH_OFF:    seq_count = tim_off;
                        default:   seq_count = tim_post_off;
                    endcase
                end else begin
                    seq_count = seq_count - 8'd1;
                    if (seq_count == 0) begin
                        case (seq_phase)
                            PH_PRE_ON: seq_phase = PH_ON;
                            PH_ON:     seq_phase = PH_OFF;
                            PH_OFF: begin
                                if (flashes_owed != 0)
                                    flashes_owed = flashes_owed - 8'd1;
                                seq_phase = (flashes_owed != 0) ? PH_ON : PH_POST_OFF;
                            end
                            default:   seq_phase = PH_IDLE;
                        endcase
                    end
                end
            end
            OP_START: begin
                flashes_owed = it.data[31:24];
                seq_phase    = PH_PRE_ON;
            end
            OP_SET_COLOR: begin
                steady_red   = it.data[7:0];
                steady_green = it.data[15:8];
                steady_blue  = it.data[23:16];
            end
            default: ;
        endcase
        r.busy_res = (seq_phase != PH_IDLE);
        return r;
    endfunction

    task automatic check_pixel(input t_result exp);
        if (m_axis_tuser[0] !== exp.pixel_write) begin
            $error("pixel_write: expected %0d, got %0d", exp.pixel_write, m_axis_tuser[0]);
            mismatches++;
        end
        if (m_axis_tdata[7:0] !== exp.pixel_red) begin
            $error("pixel_red: expected %0d, got %0d", exp.pixel_red, m_axis_tdata[7:0]);
            mismatches++;
        end
        if (m_axis_tdata[15:8] !== exp.pixel_green) begin
            $error("pixel_green: expected %0d, got %0d", exp.pixel_green, m_axis_tdata[15:8]);
            mismatches++;
        end
        if (m_axis_tdata[23:16] !== exp.pixel_blue) begin
            $error("pixel_blue: expected %0d, got %0d", exp.pixel_blue, m_axis_tdata[23:16]);
            mismatches++;
        end
        if (m_axis_tdata[24] !== exp.busy_res) begin
            $error("busy_res: expected %0d, got %0d", exp.busy_res, m_axis_tdata[24]);
            mismatches++;
        end
    endtask

    // Input driver. A transfer accepted at this edge is handed to the predictor; then the
    // next item is offered unless the sender idles. An offered item is held until taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                pixel_due.push_back(predict_pixel(on_offer));
            if (!s_axis_tvalid || s_axis_tready) begin
                if (items_to_send.size() != 0 && (calm || $urandom_range(0, 99) >= 19)) begin
                    on_offer = items_to_send.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= on_offer.data;
                    s_axis_tuser  <= on_offer.op;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Output monitor: every result transfer is matched against the oldest prediction.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (pixel_due.size() == 0) begin
                    $error("result transfer with no prediction outstanding");
                    mismatches++;
                end else begin
                    check_pixel(pixel_due.pop_front());
                end
            end
            m_axis_tready <= !hold_off && (calm || $urandom_range(0, 99) >= 19);
        end
    end

    task automatic push_item(input logic [1:0] op, input logic [31:0] data);
        items_to_send.push_back('{op: op, data: data});
        items_queued++;
    endtask

    // Writes all four timing registers, back to back, and mirrors them in the predictor.
    // Only called once the block has nothing in flight.
    task automatic write_timing(input logic [7:0] pre_len, input logic [7:0] lit_len,
                                input logic [7:0] gap_len, input logic [7:0] post_len);
        logic [1:0] idx [4];
        logic [7:0] val [4];
        idx[0] = CFG_PRE_ON;
        idx[1] = CFG_ON;
        idx[2] = CFG_OFF;
        idx[3] = CFG_POST_OFF;
        val[0] = pre_len;
        val[1] = lit_len;
        val[2] = gap_len;
        val[3] = post_len;
        for (int k = 0; k < 4; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data  <= val[k];
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        i_cfg_valid <= 1'b0;
        tim_pre_on   = pre_len;
        tim_on       = lit_len;
        tim_off      = gap_len;
        tim_post_off = post_len;
    endtask

    // Waits until every item has gone in and every result has come out, plus a margin
    // for the result register.
    task automatic wait_quiet();
        while (items_to_send.size() != 0 || s_axis_tvalid || pixel_due.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic [7:0] pick_len();
        return ($urandom_range(0, 7) == 0) ? 8'($urandom_range(1, 40))
                                           : 8'($urandom_range(1, 6));
    endfunction

    // One blink sequence: maybe a new colour, a start, then about enough ticks to play it
    // out, with the odd stray item (including restarts and the unused opcode) mixed in.
    task automatic queue_burst(input int tick_cap);
        int flashes;
        int span;
        if ($urandom_range(0, 3) == 0)
            push_item(OP_SET_COLOR, $urandom);
        flashes = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 3);
        push_item(OP_START, {8'(flashes), 24'($urandom)});
        span = tim_pre_on + 1 + flashes * (tim_on + tim_off + 2) + tim_post_off + 1
               + $urandom_range(0, 4);
        if (span > tick_cap)
            span = tick_cap;
        for (int k = 0; k < span; k++) begin
            if ($urandom_range(0, 19) == 0)
                push_item(2'($urandom_range(0, 3)), $urandom);
            else
                push_item(OP_TICK, $urandom);
        end
    endtask

    initial begin
        int phase_no;
        int target;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed opening with the reset timing (pre-on 5, on 2, off 2, post-off 5).
        push_item(OP_TICK, 32'h0000_0000);       // idle and black: nothing drawn
        push_item(OP_UNUSED, 32'hFFFF_FFFF);     // ignored opcode
        push_item(OP_SET_COLOR, 32'hFFFF_FFFF);  // full white
        push_item(OP_TICK, 32'hFFFF_FFFF);       // idle redraw of the steady colour
        push_item(OP_SET_COLOR, 32'h0000_0000);  // back to black
        push_item(OP_TICK, 32'h0000_0000);
        push_item(OP_START, 32'h0000_0000);      // zero flashes: straight to post-off
        repeat (6) push_item(OP_TICK, 32'h0000_0000);
        push_item(OP_SET_COLOR, 32'h00C3_5AA5);
        push_item(OP_START, 32'hFF00_0000);      // largest flash count
        repeat (2) push_item(OP_TICK, 32'h0000_0000);
        push_item(OP_SET_COLOR, 32'h0056_3412);  // colour change mid-sequence
        push_item(OP_START, 32'h0200_0000);      // restart while the countdown is running
        repeat (6) push_item(OP_TICK, 32'h0000_0000);
        wait_quiet();

        // Random phases, each with its own timing. The second uses zero lengths, which
        // lock a phase until the next start; the third uses the largest lengths.
        phase_no = 0;
        while (items_queued < 1750) begin
            case (phase_no)
                0:       write_timing(8'd1, 8'd1, 8'd1, 8'd1);
                1:       write_timing(8'd0, 8'd1, 8'd0, 8'd2);
                2:       write_timing(8'd255, 8'd255, 8'd255, 8'd255);
                default: write_timing(pick_len(), pick_len(), pick_len(), pick_len());
            endcase
            calm = (phase_no == 4);
            target = items_queued + ((phase_no == 1) ? 60 : (phase_no == 2) ? 250 : 150);
            while (items_queued < target)
                queue_burst((phase_no == 2) ? 200 : 120);
            if (phase_no == 3) begin
                // Block the output for a long stretch while the input keeps offering.
                hold_off = 1'b1;
                repeat (250) @(posedge i_clk);
                hold_off = 1'b0;
            end
            wait_quiet();
            phase_no++;
        end
        calm = 1'b0;

        if (mismatches == 0)
            $display("led_blink_code_sequencer test passed");
        else
            $display("led_blink_code_sequencer test failed");
        $finish;
    end

    // Watchdog, far beyond the slowest legitimate run.
    initial begin
        #2_000_000;
        $display("led_blink_code_sequencer test failed");
        $finish;
    end

endmodule

`default_nettype wire
